[rtl/core/robot_safety_mode_supervisor_assert.svh]
// Assertion macros for the robot safety mode supervisor.
// Included by the modules that check their own logic; needs clk and rst_n in scope.
`ifndef ROBOT_SAFETY_MODE_SUPERVISOR_ASSERT_SVH
`define ROBOT_SAFETY_MODE_SUPERVISOR_ASSERT_SVH
`ifndef SYNTHESIS
`define RSMS_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define RSMS_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);
`else
`define RSMS_ASSERT(label, expr, msg)
`define RSMS_ASSERT_NEXT(label, cond, expr, msg)
`endif
`endif

[rtl/core/rsms_pkg.sv]
// Shared types, codes and helpers for the robot safety mode supervisor.
// No dependencies; imported by every module of the block.
package rsms_pkg;

    typedef enum logic [3:0] {
        ST_OFF       = 4'd0,
        ST_INIT      = 4'd1,
        ST_IDLE      = 4'd2,
        ST_POSITION  = 4'd3,
        ST_CTC       = 4'd4,
        ST_IMPEDANCE = 4'd5,
        ST_TEACH     = 4'd6,
        ST_DMP       = 4'd7,
        ST_HYBRID    = 4'd8,
        ST_MINJERK   = 4'd9,
        ST_STOPPING  = 4'd10,
        ST_ESTOP     = 4'd11,
        ST_FAULT     = 4'd12
    } state_t;

    typedef enum logic [1:0] {
        MODE_EVENT = 2'd0,
        MODE_TICK  = 2'd1,
        MODE_INIT  = 2'd2
    } mode_t;

    localparam logic [3:0] EV_INIT_DONE     = 4'd0;
    localparam logic [3:0] EV_ENABLE        = 4'd1;
    localparam logic [3:0] EV_DISABLE       = 4'd2;
    localparam logic [3:0] EV_REQ_POSITION  = 4'd3;
    localparam logic [3:0] EV_REQ_CTC       = 4'd4;
    localparam logic [3:0] EV_REQ_IMPEDANCE = 4'd5;
    localparam logic [3:0] EV_REQ_TEACH     = 4'd6;
    localparam logic [3:0] EV_REQ_DMP       = 4'd7;
    localparam logic [3:0] EV_REQ_HYBRID    = 4'd8;
    localparam logic [3:0] EV_REQ_MINJERK   = 4'd9;
    localparam logic [3:0] EV_MOTION_DONE   = 4'd10;
    localparam logic [3:0] EV_STOP_REQ      = 4'd11;
    localparam logic [3:0] EV_ESTOP         = 4'd12;
    localparam logic [3:0] EV_ESTOP_RESET   = 4'd13;
    localparam logic [3:0] EV_FAULT         = 4'd14;
    localparam logic [3:0] EV_STOP_COMPLETE = 4'd15;

    localparam logic [1:0] CFG_STOP_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_DYNAMICS     = 2'd1;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [15:0] STOP_TIMEOUT_RESET = 16'd500;

    typedef struct packed {
        state_t      state_now;
        state_t      state_before;
        state_t      queued_mode;
        logic        motors_on;
        logic [31:0] latest_time;
        logic [31:0] entered_at;
        logic [31:0] stop_began_at;
        logic [31:0] move_count;
    } sup_state_t;

    typedef struct packed {
        logic [15:0] stop_timeout;
        logic        dynamics;
    } sup_cfg_t;

    typedef struct packed {
        logic        accepted;
        logic [3:0]  current_state;
        logic [3:0]  previous_state;
        logic        in_motion;
        logic        torque_mode;
        logic [31:0] transition_count;
        logic [31:0] entry_time;
    } result_t;

    function automatic logic is_motion(state_t s);
        return (s >= ST_POSITION) && (s <= ST_MINJERK);
    endfunction

    function automatic logic is_torque(state_t s);
        return (s == ST_CTC) || (s == ST_IMPEDANCE) || (s == ST_TEACH) || (s == ST_HYBRID);
    endfunction

endpackage

[rtl/core/rsms_step.sv]
// Next-state, guard and result logic for one word of the mode supervisor.
// Depends on rsms_pkg.
module rsms_step (
    input  rsms_pkg::sup_state_t cur,
    input  rsms_pkg::sup_cfg_t   cfg,
    input  logic [1:0]           mode,
    input  logic [3:0]           event_code,
    input  logic [31:0]          time_ms,
    output rsms_pkg::sup_state_t nxt_state,
    output rsms_pkg::result_t    result
);
    import rsms_pkg::*;

    logic        ev_go;
    logic [3:0]  ev;
    logic [31:0] stamp;
    logic [31:0] elapsed;
    logic        timeout_hit;
    state_t      target;
    logic        motors_ev;
    state_t      queued_ev;
    logic        force_acc;
    logic        take;
    logic        moving;
    logic        acc;

    function automatic logic guard_ok(state_t from, state_t to, logic motors, logic dyn);
        logic ok;
        ok = 1'b1;
        if (to == ST_ESTOP)
            ok = 1'b1;
        else if (from == ST_FAULT)
            ok = 1'b0;
        else if (from == ST_ESTOP && to != ST_IDLE)
            ok = 1'b0;
        else if (is_motion(to) && !motors)
            ok = 1'b0;
        else if (is_torque(to) && !dyn)
            ok = 1'b0;
        else if (is_motion(to) && from != ST_IDLE)
            ok = 1'b0;
        return ok;
    endfunction

    assign elapsed     = time_ms - cur.stop_began_at;
    assign timeout_hit = (cur.state_now == ST_STOPPING) && (elapsed >= {16'd0, cfg.stop_timeout});
    assign moving      = is_motion(cur.state_now);
    assign stamp       = (mode == MODE_TICK) ? time_ms : cur.latest_time;
    assign ev          = (mode == MODE_TICK) ? EV_STOP_COMPLETE : event_code;
    assign ev_go       = (mode == MODE_EVENT) || ((mode == MODE_TICK) && timeout_hit);

    always_comb
    begin
        target    = cur.state_now;
        motors_ev = cur.motors_on;
        queued_ev = cur.queued_mode;
        force_acc = 1'b0;
        case (ev)
            EV_INIT_DONE:
            begin
                if (cur.state_now == ST_INIT)
                    target = ST_IDLE;
            end
            EV_ENABLE:
            begin
                motors_ev = 1'b1;
                force_acc = 1'b1;
            end
            EV_DISABLE:
            begin
                motors_ev = 1'b0;
                if (moving)
                    target = ST_STOPPING;
            end
            EV_REQ_POSITION, EV_REQ_CTC, EV_REQ_IMPEDANCE, EV_REQ_TEACH,
            EV_REQ_DMP, EV_REQ_HYBRID, EV_REQ_MINJERK:
            begin
                if (cur.state_now == ST_IDLE)
                    target = state_t'(ev);
                else if (moving)
                begin
                    queued_ev = state_t'(ev);
                    target    = ST_STOPPING;
                end
            end
            EV_MOTION_DONE:
            begin
                if (moving)
                    target = ST_IDLE;
            end
            EV_STOP_REQ:
            begin
                if (moving)
                    target = ST_STOPPING;
            end
            EV_ESTOP:
            begin
                target = ST_ESTOP;
            end
            EV_ESTOP_RESET:
            begin
                if (cur.state_now == ST_ESTOP)
                    target = ST_IDLE;
            end
            EV_FAULT:
            begin
                target = ST_FAULT;
            end
            EV_STOP_COMPLETE:
            begin
                if (cur.state_now == ST_STOPPING)
                begin
                    if (cur.queued_mode != ST_OFF && cur.queued_mode != cur.state_now)
                        target = cur.queued_mode;
                    else
                        target = ST_IDLE;
                    queued_ev = ST_OFF;
                end
            end
            default:
            begin
                target = cur.state_now;
            end
        endcase
    end

    assign take = (target != cur.state_now) &&
                  guard_ok(cur.state_now, target, motors_ev, cfg.dynamics);

    always_comb
    begin
        nxt_state = cur;
        acc       = 1'b0;
        case (mode)
            MODE_EVENT, MODE_TICK:
            begin
                if (mode == MODE_TICK)
                    nxt_state.latest_time = time_ms;
                if (ev_go)
                begin
                    nxt_state.motors_on   = motors_ev;
                    nxt_state.queued_mode = queued_ev;
                    if (force_acc)
                        acc = 1'b1;
                    else if (take)
                    begin
                        acc                    = 1'b1;
                        nxt_state.state_before = cur.state_now;
                        nxt_state.state_now    = target;
                        nxt_state.entered_at   = stamp;
                        nxt_state.move_count   = cur.move_count + 32'd1;
                        if (target == ST_STOPPING)
                            nxt_state.stop_began_at = stamp;
                    end
                end
            end
            MODE_INIT:
            begin
                acc                    = 1'b1;
                nxt_state.state_now    = ST_INIT;
                nxt_state.state_before = ST_OFF;
                nxt_state.latest_time  = 32'd0;
                nxt_state.entered_at   = 32'd0;
                nxt_state.move_count   = 32'd0;
            end
            default:
            begin
                acc = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        result.accepted         = acc;
        result.current_state    = nxt_state.state_now;
        result.previous_state   = nxt_state.state_before;
        result.in_motion        = is_motion(nxt_state.state_now);
        result.torque_mode      = is_torque(nxt_state.state_now);
        result.transition_count = nxt_state.move_count;
        result.entry_time       = nxt_state.entered_at;
    end

endmodule

[rtl/core/rsms_out_reg.sv]
// Result register of the mode supervisor: holds one result word until taken.
// Depends on rsms_pkg.
module rsms_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  rsms_pkg::result_t load_data,
    input  logic              out_stall,
    output logic              out_valid,
    output logic              busy,
    output rsms_pkg::result_t out_data
);
    import rsms_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign valid_next = load || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign out_valid = valid_reg;
    assign busy      = valid_reg && out_stall;
    assign out_data  = data_reg;

endmodule

[rtl/core/robot_safety_mode_supervisor.sv]
// Robot safety mode supervisor: 13-state operating mode tracker with guards.
// A result word is registered and appears in the cycle after its input word is accepted.
// Throughput: one word per cycle while the input is not stalled; the state update and guard are combinational.
// Input stalls only while a finished result waits behind a stalled output.
// Reset (asynchronous, active low): powered off, counters and times zero,
// stopping timeout 500 ms, dynamics unavailable.
module robot_safety_mode_supervisor (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      mode,
    input  logic [3:0]                      event_code,
    input  logic [31:0]                     time_ms,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            accepted,
    output logic [3:0]                      current_state,
    output logic [3:0]                      previous_state,
    output logic                            in_motion,
    output logic                            torque_mode,
    output logic [31:0]                     transition_count,
    output logic [31:0]                     entry_time,
    input  logic                            cfg_we,
    input  logic [rsms_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rsms_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rsms_pkg::*;

`include "robot_safety_mode_supervisor_assert.svh"

    sup_state_t state_reg;
    sup_state_t state_next;
    sup_cfg_t   cfg_reg;
    result_t    step_result;
    result_t    out_data;
    logic       take_in;
    logic       busy;

    assign in_stall = busy;
    assign take_in  = in_valid && !busy;

    rsms_step u_step (
        .cur        (state_reg),
        .cfg        (cfg_reg),
        .mode       (mode),
        .event_code (event_code),
        .time_ms    (time_ms),
        .nxt_state  (state_next),
        .result     (step_result)
    );

    rsms_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take_in),
        .load_data (step_result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .busy      (busy),
        .out_data  (out_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.state_now     <= ST_OFF;
            state_reg.state_before  <= ST_OFF;
            state_reg.queued_mode   <= ST_OFF;
            state_reg.motors_on     <= 1'b0;
            state_reg.latest_time   <= 32'd0;
            state_reg.entered_at    <= 32'd0;
            state_reg.stop_began_at <= 32'd0;
            state_reg.move_count    <= 32'd0;
        end
        else if (take_in)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stop_timeout <= STOP_TIMEOUT_RESET;
            cfg_reg.dynamics     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STOP_TIMEOUT: cfg_reg.stop_timeout <= cfg_data;
                CFG_DYNAMICS:     cfg_reg.dynamics     <= cfg_data[0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    assign accepted         = out_data.accepted;
    assign current_state    = out_data.current_state;
    assign previous_state   = out_data.previous_state;
    assign in_motion        = out_data.in_motion;
    assign torque_mode      = out_data.torque_mode;
    assign transition_count = out_data.transition_count;
    assign entry_time       = out_data.entry_time;

    `RSMS_ASSERT_NEXT(a_accept_gives_result, take_in, out_valid, "accepted word gave no result")
    `RSMS_ASSERT_NEXT(a_fault_terminal,
        take_in && state_reg.state_now == ST_FAULT && mode != MODE_INIT &&
        !(mode == MODE_EVENT && event_code == EV_ESTOP),
        state_reg.state_now == ST_FAULT, "fault state was left")
    `RSMS_ASSERT_NEXT(a_count_step, take_in && mode != MODE_INIT,
        state_reg.move_count == $past(state_reg.move_count) ||
        state_reg.move_count == $past(state_reg.move_count) + 32'd1,
        "transition count jumped")
    `RSMS_ASSERT_NEXT(a_motion_from_idle, take_in && !is_motion(state_reg.state_now),
        !is_motion(state_reg.state_now) || state_reg.state_before == ST_IDLE,
        "motion state entered from a state other than idle")
    `RSMS_ASSERT(a_result_matches_state,
        !out_valid || is_motion(state_t'(current_state)) == in_motion,
        "motion flag disagrees with state")

endmodule
